// ===== hw/rtl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the height-map bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    // Fraction bits of the position (Q15.8), of the scale (Q8.8) and of depth (Q8.8)
    localparam int unsigned POS_FRAC_BITS   = 8;
    localparam int unsigned PPM_FRAC_BITS   = 8;
    localparam int unsigned DEPTH_FRAC_BITS = 8;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [15:0] PPM_RESET   = 16'd256;
    localparam logic [15:0] DEPTH_RESET = 16'd7680;

    typedef enum logic
    {
        KIND_LOAD   = 1'b0,
        KIND_SAMPLE = 1'b1
    } hbs_kind_t;

    typedef enum logic [1:0]
    {
        REG_MAP_WIDTH        = 2'd0,
        REG_MAP_HEIGHT       = 2'd1,
        REG_PIXELS_PER_METER = 2'd2,
        REG_DEPTH_METERS     = 2'd3
    } hbs_reg_t;

    typedef struct packed
    {
        logic [15:0] map_width;
        logic [15:0] map_height;
        logic [15:0] pixels_per_meter;
        logic [15:0] depth_meters;
    } hbs_cfg_t;

    // Classified request handed from the front end to the back end
    typedef struct packed
    {
        hbs_kind_t   kind;
        logic        in_map;
        logic [15:0] load_addr;
        logic [7:0]  load_value;
        logic [15:0] xi;
        logic [15:0] x2;
        logic [15:0] yi;
        logic [15:0] y2;
    } hbs_cmd_t;

endpackage

// ===== hw/rtl/hbs_front.sv =====
// ----------------------------------------------------------------------------
// hbs_front
// Accepts requests, scales positions to pixels and classifies each sample.
// ----------------------------------------------------------------------------
module hbs_front #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hbs_pkg::hbs_cfg_t        cfg,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pixel_address[15:0], pixel_value[23:16], x_position[47:24], y_position[71:48]
    input  logic [71:0]              s_tdata,
    // kind[0]
    input  logic                     s_tuser,
    input  logic                     q_full,
    output logic                     push,
    output hbs_pkg::hbs_cmd_t        cmd,
    output logic [FRACTION_BITS-1:0] fx,
    output logic [FRACTION_BITS-1:0] fy
);

    localparam int unsigned FB    = FRACTION_BITS;
    localparam int unsigned PW    = 41;
    localparam int unsigned UW    = PW + 1;
    localparam int unsigned SHIFT = hbs_pkg::POS_FRAC_BITS + hbs_pkg::PPM_FRAC_BITS - FB;

    logic                    adv;
    logic                    f1_valid_reg;
    logic                    f2_valid_reg;
    logic                    f3_valid_reg;
    logic signed [23:0]      x_pos;
    logic signed [23:0]      y_pos;
    logic signed [PW-1:0]    px_next;
    logic signed [PW-1:0]    py_next;
    logic signed [PW-1:0]    f1_px_reg;
    logic signed [PW-1:0]    f1_py_reg;
    hbs_pkg::hbs_kind_t      f1_kind_reg;
    hbs_pkg::hbs_kind_t      f2_kind_reg;
    logic [15:0]             f1_addr_reg;
    logic [15:0]             f2_addr_reg;
    logic [7:0]              f1_value_reg;
    logic [7:0]              f2_value_reg;
    logic [UW-1:0]           off_x;
    logic [UW-1:0]           off_y;
    logic signed [UW-1:0]    ux_next;
    logic signed [UW-1:0]    uy_next;
    logic signed [UW-1:0]    f2_ux_reg;
    logic signed [UW-1:0]    f2_uy_reg;
    logic [15:0]             xi;
    logic [15:0]             yi;
    logic                    in_x;
    logic                    in_y;
    hbs_pkg::hbs_cmd_t       cmd_next;
    logic [FB-1:0]           fx_next;
    logic [FB-1:0]           fy_next;
    hbs_pkg::hbs_cmd_t       f3_cmd_reg;
    logic [FB-1:0]           f3_fx_reg;
    logic [FB-1:0]           f3_fy_reg;

    assign adv      = !(f3_valid_reg && q_full);
    assign s_tready = adv;
    assign push     = f3_valid_reg && adv;
    assign cmd      = f3_cmd_reg;
    assign fx       = f3_fx_reg;
    assign fy       = f3_fy_reg;

    // Stage 1: position times scale
    assign x_pos   = s_tdata[47:24];
    assign y_pos   = s_tdata[71:48];
    assign px_next = x_pos * $signed({1'b0, cfg.pixels_per_meter});
    assign py_next = y_pos * $signed({1'b0, cfg.pixels_per_meter});

    // Stage 2: floor to pixel fraction, add centering offset
    assign off_x   = UW'(cfg.map_width[15:1]) << FB;
    assign off_y   = UW'(cfg.map_height[15:1]) << FB;
    assign ux_next = UW'(f1_px_reg >>> SHIFT) + $signed(off_x);
    assign uy_next = UW'(f1_py_reg >>> SHIFT) + $signed(off_y);

    // Stage 3: inside test and neighbor indexes
    always_comb
    begin
        xi   = f2_ux_reg[FB+15:FB];
        yi   = f2_uy_reg[FB+15:FB];
        in_x = (f2_ux_reg[UW-1:FB+16] == '0) && (xi != 16'd0) && (xi < cfg.map_width);
        in_y = (f2_uy_reg[UW-1:FB+16] == '0) && (yi != 16'd0) && (yi < cfg.map_height);

        cmd_next.kind       = f2_kind_reg;
        cmd_next.in_map     = in_x && in_y;
        cmd_next.load_addr  = f2_addr_reg;
        cmd_next.load_value = f2_value_reg;
        cmd_next.xi         = xi;
        cmd_next.yi         = yi;
        // far neighbor clamps to the last column / row
        cmd_next.x2 = ((17'(xi) + 17'd1) == 17'(cfg.map_width)) ? xi : xi + 16'd1;
        cmd_next.y2 = ((17'(yi) + 17'd1) == 17'(cfg.map_height)) ? yi : yi + 16'd1;

        fx_next = f2_ux_reg[FB-1:0];
        fy_next = f2_uy_reg[FB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= s_tvalid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_kind_reg  <= hbs_pkg::hbs_kind_t'(s_tuser);
            f1_addr_reg  <= s_tdata[15:0];
            f1_value_reg <= s_tdata[23:16];
            f1_px_reg    <= px_next;
            f1_py_reg    <= py_next;
            f2_kind_reg  <= f1_kind_reg;
            f2_addr_reg  <= f1_addr_reg;
            f2_value_reg <= f1_value_reg;
            f2_ux_reg    <= ux_next;
            f2_uy_reg    <= uy_next;
            f3_cmd_reg   <= cmd_next;
            f3_fx_reg    <= fx_next;
            f3_fy_reg    <= fy_next;
        end
    end

endmodule

// ===== hw/rtl/hbs_queue.sv =====
// ----------------------------------------------------------------------------
// hbs_queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module hbs_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid,
    output logic             full
);

    localparam int unsigned PTRW = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PTRW-1:0]  wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_next;
    logic [CW-1:0]    count_next;

    assign rdata = entry_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign full  = (count_reg == CW'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != CW'(DEPTH))
        else $error("push into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not rise on push");

endmodule

// ===== hw/rtl/hbs_back.sv =====
// ----------------------------------------------------------------------------
// hbs_back
// Pixel store, neighbor fetch, bilinear blend, depth scaling and output stage.
// ----------------------------------------------------------------------------
module hbs_back #(
    parameter int unsigned MAP_PIXELS    = 65536,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hbs_pkg::hbs_cfg_t        cfg,
    input  logic                     q_valid,
    input  hbs_pkg::hbs_cmd_t        q_cmd,
    input  logic [FRACTION_BITS-1:0] q_fx,
    input  logic [FRACTION_BITS-1:0] q_fy,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // height_value[23:0]
    output logic [23:0]              m_tdata,
    // outside_map[0]
    output logic                     m_tuser
);

    localparam int unsigned FB     = FRACTION_BITS;
    localparam int unsigned AW     = $clog2(MAP_PIXELS);
    localparam logic [32:0] LIMIT  = 33'(MAP_PIXELS);
    localparam logic [FB:0] ONE    = (FB + 1)'(1) << FB;
    localparam int unsigned TW     = FB + 8;
    localparam int unsigned SW     = 2 * FB + 8;
    localparam int unsigned PRW    = SW + 16;
    localparam int unsigned HSHIFT = 2 * FB + hbs_pkg::DEPTH_FRAC_BITS;

    logic adv;
    logic we;

    // stage 1: row bases
    logic               b1_valid_reg;
    hbs_pkg::hbs_kind_t b1_kind_reg;
    logic               b1_inside_reg;
    logic [15:0]        b1_xi_reg;
    logic [15:0]        b1_x2_reg;
    logic [31:0]        b1_r0_reg;
    logic [31:0]        b1_r1_reg;
    logic [15:0]        b1_addr_reg;
    logic [7:0]         b1_value_reg;
    logic [FB-1:0]      b1_fx_reg;
    logic [FB-1:0]      b1_fy_reg;
    logic [31:0]        r0_next;
    logic [31:0]        r1_next;

    // stage 2: pixel addresses
    logic [31:0]        a00;
    logic [31:0]        a10;
    logic [31:0]        a01;
    logic [31:0]        a11;
    logic [31:0]        wa;
    logic               b2_valid_reg;
    logic               b2_sample_reg;
    logic               b2_inside_reg;
    logic [AW-1:0]      b2_a00_reg;
    logic [AW-1:0]      b2_a10_reg;
    logic [AW-1:0]      b2_a01_reg;
    logic [AW-1:0]      b2_a11_reg;
    logic [3:0]         b2_ok_reg;
    logic               b2_wr_ok_reg;
    logic [AW-1:0]      b2_waddr_reg;
    logic [7:0]         b2_wvalue_reg;
    logic [FB-1:0]      b2_fx_reg;
    logic [FB-1:0]      b2_fy_reg;

    // stage 3: pixel reads
    logic [7:0]         mem_a [MAP_PIXELS];
    logic [7:0]         mem_b [MAP_PIXELS];
    logic               b3_valid_reg;
    logic               b3_sample_reg;
    logic               b3_inside_reg;
    logic [7:0]         b3_c00_reg;
    logic [7:0]         b3_c10_reg;
    logic [7:0]         b3_c01_reg;
    logic [7:0]         b3_c11_reg;
    logic [3:0]         b3_ok_reg;
    logic [FB-1:0]      b3_fx_reg;
    logic [FB-1:0]      b3_fy_reg;

    // stage 4: horizontal blend
    logic [7:0]         c00;
    logic [7:0]         c10;
    logic [7:0]         c01;
    logic [7:0]         c11;
    logic [FB:0]        omfx;
    logic [TW-1:0]      top_next;
    logic [TW-1:0]      bot_next;
    logic               b4_valid_reg;
    logic               b4_inside_reg;
    logic [TW-1:0]      b4_top_reg;
    logic [TW-1:0]      b4_bot_reg;
    logic [FB-1:0]      b4_fy_reg;

    // stage 5: vertical blend
    logic [FB:0]        omfy;
    logic [SW-1:0]      sum_next;
    logic               b5_valid_reg;
    logic               b5_inside_reg;
    logic [SW-1:0]      b5_sum_reg;

    // stage 6: depth scale
    logic               b6_valid_reg;
    logic               b6_inside_reg;
    logic [PRW-1:0]     b6_prod_reg;

    // output register
    logic               out_valid_reg;
    logic [23:0]        out_height_reg;
    logic               out_outside_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign pop      = adv && q_valid;
    assign we       = adv && b2_valid_reg && b2_wr_ok_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_height_reg;
    assign m_tuser  = out_outside_reg;

    assign r0_next = q_cmd.yi * cfg.map_width;
    assign r1_next = q_cmd.y2 * cfg.map_width;

    assign a00 = b1_r0_reg + 32'(b1_xi_reg);
    assign a10 = b1_r0_reg + 32'(b1_x2_reg);
    assign a01 = b1_r1_reg + 32'(b1_xi_reg);
    assign a11 = b1_r1_reg + 32'(b1_x2_reg);
    assign wa  = 32'(b1_addr_reg);

    always_comb
    begin
        c00      = b3_ok_reg[0] ? b3_c00_reg : 8'd0;
        c10      = b3_ok_reg[1] ? b3_c10_reg : 8'd0;
        c01      = b3_ok_reg[2] ? b3_c01_reg : 8'd0;
        c11      = b3_ok_reg[3] ? b3_c11_reg : 8'd0;
        omfx     = ONE - (FB + 1)'(b3_fx_reg);
        top_next = TW'(c00) * TW'(omfx) + TW'(c10) * TW'(b3_fx_reg);
        bot_next = TW'(c01) * TW'(omfx) + TW'(c11) * TW'(b3_fx_reg);
        omfy     = ONE - (FB + 1)'(b4_fy_reg);
        sum_next = SW'(b4_top_reg) * SW'(omfy) + SW'(b4_bot_reg) * SW'(b4_fy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            b6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            // loads end at the store
            b4_valid_reg  <= b3_valid_reg && b3_sample_reg;
            b5_valid_reg  <= b4_valid_reg;
            b6_valid_reg  <= b5_valid_reg;
            out_valid_reg <= b6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_kind_reg   <= q_cmd.kind;
            b1_inside_reg <= q_cmd.in_map;
            b1_xi_reg     <= q_cmd.xi;
            b1_x2_reg     <= q_cmd.x2;
            b1_r0_reg     <= r0_next;
            b1_r1_reg     <= r1_next;
            b1_addr_reg   <= q_cmd.load_addr;
            b1_value_reg  <= q_cmd.load_value;
            b1_fx_reg     <= q_fx;
            b1_fy_reg     <= q_fy;

            b2_sample_reg <= (b1_kind_reg == hbs_pkg::KIND_SAMPLE);
            b2_inside_reg <= b1_inside_reg;
            b2_a00_reg    <= a00[AW-1:0];
            b2_a10_reg    <= a10[AW-1:0];
            b2_a01_reg    <= a01[AW-1:0];
            b2_a11_reg    <= a11[AW-1:0];
            b2_ok_reg     <= {({1'b0, a11} < LIMIT), ({1'b0, a01} < LIMIT),
                              ({1'b0, a10} < LIMIT), ({1'b0, a00} < LIMIT)};
            b2_wr_ok_reg  <= (b1_kind_reg == hbs_pkg::KIND_LOAD) && ({1'b0, wa} < LIMIT);
            b2_waddr_reg  <= wa[AW-1:0];
            b2_wvalue_reg <= b1_value_reg;
            b2_fx_reg     <= b1_fx_reg;
            b2_fy_reg     <= b1_fy_reg;

            b3_sample_reg <= b2_sample_reg;
            b3_inside_reg <= b2_inside_reg;
            b3_ok_reg     <= b2_ok_reg;
            b3_fx_reg     <= b2_fx_reg;
            b3_fy_reg     <= b2_fy_reg;

            b4_inside_reg <= b3_inside_reg;
            b4_top_reg    <= top_next;
            b4_bot_reg    <= bot_next;
            b4_fy_reg     <= b3_fy_reg;

            b5_inside_reg <= b4_inside_reg;
            b5_sum_reg    <= sum_next;

            b6_inside_reg <= b5_inside_reg;
            b6_prod_reg   <= PRW'(b5_sum_reg) * PRW'(cfg.depth_meters);

            // the scaled blend never exceeds 16 integer bits, so no clipping
            out_height_reg  <= b6_inside_reg ? 24'(b6_prod_reg[PRW-1:HSHIFT]) : 24'd0;
            out_outside_reg <= !b6_inside_reg;
        end
    end

    // copy A serves the upper row, copy B the lower row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_a[b2_waddr_reg] <= b2_wvalue_reg;
        end
        if (adv)
        begin
            b3_c00_reg <= mem_a[b2_a00_reg];
            b3_c10_reg <= mem_a[b2_a10_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_b[b2_waddr_reg] <= b2_wvalue_reg;
        end
        if (adv)
        begin
            b3_c01_reg <= mem_b[b2_a01_reg];
            b3_c11_reg <= mem_b[b2_a11_reg];
        end
    end

endmodule

// ===== hw/rtl/heightmap_bilinear_sampler_top.sv =====
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_top
// Byte-per-pixel height map with bilinear sampling at world positions.
//
// A request with tuser 0 writes one pixel of the map; a request with tuser 1
// samples the map at a signed Q15.8 world position and returns one Q24.0 integer
// height, or zero with the outside flag when the position falls off the map.
// One request is taken every clock while the output is not stalled. All four
// neighbor pixels of a sample are read in the same cycle from two copies of
// the map, each copy with one write port and two read ports. Loads and
// samples stay in order, so a sample sees every load accepted before it.
// Configuration registers may change only while no request is in flight.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_top #(
    parameter int unsigned MAP_PIXELS    = 65536,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_address[15:0], pixel_value[23:16], x_position[47:24], y_position[71:48]
    input  logic [71:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // height_value[23:0]
    output logic [23:0] m_tdata,
    // outside_map[0]
    output logic        m_tuser
);

    localparam int unsigned FB = FRACTION_BITS;
    localparam int unsigned QW = $bits(hbs_pkg::hbs_cmd_t) + 2 * FB;

    hbs_pkg::hbs_cfg_t cfg_reg;
    logic              push;
    logic              pop;
    logic              q_valid;
    logic              q_full;
    hbs_pkg::hbs_cmd_t f_cmd;
    logic [FB-1:0]     f_fx;
    logic [FB-1:0]     f_fy;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    hbs_pkg::hbs_cmd_t q_cmd;
    logic [FB-1:0]     q_fx;
    logic [FB-1:0]     q_fy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width        <= 16'd0;
            cfg_reg.map_height       <= 16'd0;
            cfg_reg.pixels_per_meter <= hbs_pkg::PPM_RESET;
            cfg_reg.depth_meters     <= hbs_pkg::DEPTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (hbs_pkg::hbs_reg_t'(cfg_index))
                hbs_pkg::REG_MAP_WIDTH:        cfg_reg.map_width        <= cfg_data;
                hbs_pkg::REG_MAP_HEIGHT:       cfg_reg.map_height       <= cfg_data;
                hbs_pkg::REG_PIXELS_PER_METER: cfg_reg.pixels_per_meter <= cfg_data;
                hbs_pkg::REG_DEPTH_METERS:     cfg_reg.depth_meters     <= cfg_data;
                default:                       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    hbs_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (f_cmd),
        .fx       (f_fx),
        .fy       (f_fy)
    );

    assign q_wdata = {f_fy, f_fx, f_cmd};

    hbs_queue #(
        .WIDTH (QW),
        .DEPTH (hbs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .rdata (q_rdata),
        .valid (q_valid),
        .full  (q_full)
    );

    assign {q_fy, q_fx, q_cmd} = q_rdata;

    hbs_back #(
        .MAP_PIXELS    (MAP_PIXELS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_fx     (q_fx),
        .q_fy     (q_fy),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/tb_heightmap_bilinear_sampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_bilinear_sampler_top
// Self-checking bench for the height-map bilinear sampler.
//
// A queue of pixel loads and height samples feeds a clocked driver. A monitor
// keeps its own copy of the map and registers, works out the height of every
// accepted sample and compares the returned results in order. The map size,
// scale and depth are changed between phases, from empty and tiny maps up
// to the largest, with samples aimed at map edges, clamped far corners and
// rows past the end of the store. Both sides stall at random, apart from the final phases.
// ----------------------------------------------------------------------------
module tb_heightmap_bilinear_sampler_top;

    localparam int STORE_SIZE     = 65536;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed
    {
        hbs_pkg::hbs_kind_t kind;
        logic [71:0]        data;
    } map_request_t;

    typedef struct packed
    {
        logic [23:0] height;
        logic        off_map;
    } height_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = 72'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    map_request_t   pending_requests[$];
    height_result_t expected_heights[$];

    logic [7:0]  height_mem [0:STORE_SIZE-1];
    bit          pix_loaded [0:STORE_SIZE-1];
    logic [15:0] map_w   = 16'd0;
    logic [15:0] map_h   = 16'd0;
    logic [15:0] ppm_q   = hbs_pkg::PPM_RESET;
    logic [15:0] depth_q = hbs_pkg::DEPTH_RESET;

    int src_idle_pct  = 21;
    int sink_idle_pct = 45;
    int err_count     = 0;
    int stall_cycles  = 0;

    heightmap_bilinear_sampler_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Height prediction
    // ------------------------------------------------------------------
    function automatic longint to_pixel_q8(logic [23:0] pos, logic [15:0] extent);
        longint prod;
        prod = longint'($signed(pos)) * longint'({1'b0, ppm_q});
        return (prod >>> 8) + (longint'(extent >> 1) << 8);
    endfunction

    function automatic void locate(input logic [23:0] xp, input logic [23:0] yp,
                                   output bit on_map,
                                   output longint a00, output longint a10,
                                   output longint a01, output longint a11,
                                   output int fx, output int fy);
        longint u;
        longint v;
        longint xi;
        longint yi;
        longint x2;
        longint y2;
        u      = to_pixel_q8(xp, map_w);
        v      = to_pixel_q8(yp, map_h);
        xi     = u >>> 8;
        yi     = v >>> 8;
        fx     = int'(u[7:0]);
        fy     = int'(v[7:0]);
        on_map = xi > 0 && xi < longint'(map_w) && yi > 0 && yi < longint'(map_h);
        // far corner clamps to the last column / row
        x2 = xi + 1;
        y2 = yi + 1;
        if (x2 > longint'(map_w) - 1)
            x2 = longint'(map_w) - 1;
        if (y2 > longint'(map_h) - 1)
            y2 = longint'(map_h) - 1;
        a00 = yi * longint'(map_w) + xi;
        a10 = yi * longint'(map_w) + x2;
        a01 = y2 * longint'(map_w) + xi;
        a11 = y2 * longint'(map_w) + x2;
    endfunction

    function automatic longint read_px(longint addr);
        if (addr < STORE_SIZE)
            return longint'(height_mem[addr[15:0]]);
        return 0;
    endfunction

    function automatic height_result_t predict_height(logic [23:0] xp, logic [23:0] yp);
        bit             on_map;
        longint         a00;
        longint         a10;
        longint         a01;
        longint         a11;
        int             fx;
        int             fy;
        longint         top_row;
        longint         bot_row;
        longint         h;
        height_result_t r;
        locate(xp, yp, on_map, a00, a10, a01, a11, fx, fy);
        r.height  = 24'd0;
        r.off_map = 1'b1;
        if (on_map)
        begin
            top_row = read_px(a00) * (256 - fx) + read_px(a10) * fx;
            bot_row = read_px(a01) * (256 - fx) + read_px(a11) * fx;
            h = ((top_row * (256 - fy) + bot_row * fy) * longint'({1'b0, depth_q})) >>> 24;
            if (h > 64'hFF_FFFF)
                h = 64'hFF_FFFF;
            r.height  = h[23:0];
            r.off_map = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    task automatic push_load(logic [15:0] addr, logic [7:0] value);
        map_request_t req;
        logic [23:0]  junk_x;
        logic [23:0]  junk_y;
        junk_x   = $urandom;
        junk_y   = $urandom;
        req.kind = hbs_pkg::KIND_LOAD;
        req.data = {junk_y, junk_x, value, addr};
        pix_loaded[addr] = 1'b1;
        pending_requests.push_back(req);
    endtask

    task automatic push_sample(logic [23:0] xp, logic [23:0] yp);
        map_request_t req;
        logic [15:0]  junk_addr;
        logic [7:0]   junk_val;
        junk_addr = $urandom;
        junk_val  = $urandom;
        req.kind  = hbs_pkg::KIND_SAMPLE;
        req.data  = {yp, xp, junk_val, junk_addr};
        pending_requests.push_back(req);
    endtask

    // a sample may only touch pixels already loaded (or past the store)
    function automatic bit sample_ok(logic [23:0] xp, logic [23:0] yp);
        bit     on_map;
        longint a00;
        longint a10;
        longint a01;
        longint a11;
        int     fx;
        int     fy;
        locate(xp, yp, on_map, a00, a10, a01, a11, fx, fy);
        if (!on_map)
            return 1'b1;
        return (a00 >= STORE_SIZE || pix_loaded[a00[15:0]]) &&
               (a10 >= STORE_SIZE || pix_loaded[a10[15:0]]) &&
               (a01 >= STORE_SIZE || pix_loaded[a01[15:0]]) &&
               (a11 >= STORE_SIZE || pix_loaded[a11[15:0]]);
    endfunction

    // world position that lands near pixel (pix + frac/256)
    function automatic logic [23:0] aim(int pix, int frac, logic [15:0] extent);
        longint t;
        longint p;
        if (ppm_q == 16'd0)
            return 24'($urandom);
        t = (longint'(pix) << 8) + frac - (longint'(extent >> 1) << 8);
        p = (t <<< 8) / longint'({1'b0, ppm_q});
        if (p > 8388607)
            p = 8388607;
        if (p < -8388608)
            p = -8388608;
        return p[23:0];
    endfunction

    task automatic fill_map(int base, int count);
        for (int i = 0; i < count; i++)
            push_load(16'(base + i), 8'($urandom));
    endtask

    task automatic gen_traffic(int n, int load_pct, int base, int span,
                               int col_lo, int col_hi, int row_lo, int row_hi, int far_pct);
        logic [23:0] xp;
        logic [23:0] yp;
        bit          ok;
        for (int i = 0; i < n; i++)
        begin
            ok = 1'b0;
            if ($urandom_range(99) >= load_pct)
            begin
                for (int t = 0; t < 8 && !ok; t++)
                begin
                    if ($urandom_range(99) < far_pct)
                    begin
                        xp = $urandom;
                        yp = $urandom;
                    end
                    else
                    begin
                        xp = aim(int'($urandom_range(col_hi - col_lo)) + col_lo,
                                 $urandom_range(255), map_w);
                        yp = aim(int'($urandom_range(row_hi - row_lo)) + row_lo,
                                 $urandom_range(255), map_h);
                    end
                    ok = sample_ok(xp, yp);
                end
            end
            if (ok)
                push_sample(xp, yp);
            else
                push_load(16'(base + int'($urandom_range(span - 1))), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_heights.size() != 0);
        // trailing loads give no result
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(hbs_pkg::hbs_reg_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            hbs_pkg::REG_MAP_WIDTH:        map_w   = value;
            hbs_pkg::REG_MAP_HEIGHT:       map_h   = value;
            hbs_pkg::REG_PIXELS_PER_METER: ppm_q   = value;
            hbs_pkg::REG_DEPTH_METERS:     depth_q = value;
        endcase
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_map(logic [15:0] w, logic [15:0] h, logic [15:0] ppm, logic [15:0] depth);
        wait_idle();
        write_reg(hbs_pkg::REG_MAP_WIDTH, w);
        write_reg(hbs_pkg::REG_MAP_HEIGHT, h);
        write_reg(hbs_pkg::REG_PIXELS_PER_METER, ppm);
        write_reg(hbs_pkg::REG_DEPTH_METERS, depth);
    endtask

    task automatic flag_mismatch(string field, longint want, longint got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        map_request_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.data;
                    s_tuser  <= req.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= $urandom_range(99) >= sink_idle_pct;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        height_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == hbs_pkg::KIND_SAMPLE)
                    expected_heights.push_back(predict_height(s_tdata[47:24], s_tdata[71:48]));
                else
                    height_mem[s_tdata[15:0]] = s_tdata[23:16];
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_heights.size() == 0)
                    flag_mismatch("unexpected result", 0, {m_tuser, m_tdata});
                else
                begin
                    want = expected_heights.pop_front();
                    if (m_tdata !== want.height)
                        flag_mismatch("height_value", want.height, m_tdata);
                    if (m_tuser !== want.off_map)
                        flag_mismatch("outside_map", want.off_map, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** heightmap_bilinear_sampler_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: zero-size map, everything falls outside
        push_load(16'd65535, 8'd255);
        push_load(16'd0, 8'd0);
        push_sample(24'd0, 24'd0);
        push_sample(24'h800000, 24'h7FFFFF);
        push_sample(24'h7FFFFF, 24'h800000);

        // 4x3 map, unit scale, full depth
        set_map(16'd4, 16'd3, 16'd256, 16'd65535);
        push_load(16'd0, 8'd0);
        push_load(16'd1, 8'd255);
        push_load(16'd2, 8'd17);
        push_load(16'd3, 8'd200);
        push_load(16'd4, 8'd99);
        push_load(16'd5, 8'd255);
        push_load(16'd6, 8'd0);
        push_load(16'd7, 8'd128);
        push_load(16'd8, 8'd1);
        push_load(16'd9, 8'd254);
        push_load(16'd10, 8'd60);
        push_load(16'd11, 8'd3);
        push_sample(24'd0, 24'd0);
        push_sample(24'd383, 24'd383);          // last column and row: clamped corner
        push_sample(-24'sd1, 24'd100);          // negative fraction
        push_sample(24'd200, 24'd150);
        push_sample(-24'sd257, 24'd0);          // column zero
        push_sample(24'd512, 24'd0);            // column == width
        push_sample(24'd0, -24'sd256);          // row zero
        push_sample(24'd0, 24'd512);            // row == height

        set_map(16'd8, 16'd8, 16'd256, 16'd7680);
        fill_map(0, 64);
        gen_traffic(100, 20, 0, 64, -1, 8, -1, 8, 5);

        set_map(16'd10, 16'd8, 16'd65535, 16'd0);
        fill_map(0, 80);
        gen_traffic(100, 20, 0, 80, -1, 10, -1, 8, 5);

        // largest map: every neighbor lies past the store
        set_map(16'd65535, 16'd65535, 16'd0, 16'd65535);
        gen_traffic(100, 40, 0, STORE_SIZE, 0, 1, 0, 1, 100);

        wait_idle();
        src_idle_pct  = 45;
        sink_idle_pct = 21;
        set_map(16'd65535, 16'd65535, 16'($urandom_range(1, 65535)), 16'($urandom));
        gen_traffic(150, 40, 0, STORE_SIZE, 0, 1, 0, 1, 100);

        // last rows in the store, lower rows beyond it
        set_map(16'd32, 16'd2100, 16'd256, 16'd256);
        fill_map(65472, 64);
        gen_traffic(100, 10, 65472, 64, 0, 32, 2045, 2049, 5);

        // smallest map with an inside pixel
        set_map(16'd2, 16'd2, 16'd128, 16'd30000);
        fill_map(0, 4);
        gen_traffic(100, 15, 0, 4, 0, 2, 0, 2, 5);

        wait_idle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_map(16'd0, 16'd5, 16'd256, 16'd7680);
        gen_traffic(40, 30, 0, STORE_SIZE, 0, 1, 0, 1, 60);

        set_map(16'd5, 16'd0, 16'd512, 16'd7680);
        gen_traffic(40, 30, 0, STORE_SIZE, 0, 1, 0, 1, 60);

        set_map(16'd12, 16'd10, 16'($urandom_range(64, 1024)), 16'($urandom));
        fill_map(0, 120);
        gen_traffic(120, 15, 0, 120, -1, 12, -1, 10, 5);
        wait_idle();
        gen_traffic(120, 15, 0, 120, -1, 12, -1, 10, 5);

        wait_idle();
        if (err_count == 0)
            $display("** heightmap_bilinear_sampler_top: PASSED **");
        else
            $display("** heightmap_bilinear_sampler_top: FAILED **");
        $finish;
    end

endmodule

// ===== heightmap_bilinear_sampler_top.f =====
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_front.sv
hw/rtl/hbs_queue.sv
hw/rtl/hbs_back.sv
hw/rtl/heightmap_bilinear_sampler_top.sv
tb/sv/tb_heightmap_bilinear_sampler_top.sv
